### hw/rtl/arpc_pkg.sv
// Shared types and constants of the ARP cache and responder.
`default_nettype none

package arpc_pkg;

  localparam int unsigned DEF_CACHE_ENTRIES = 8;

  localparam int unsigned IN_TDATA_W  = 176;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_ADDR_W  = 4;

  localparam logic [1:0] FUNC_RESOLVE = 2'd0;
  localparam logic [1:0] FUNC_PACKET  = 2'd1;
  localparam logic [1:0] FUNC_UPDATE  = 2'd2;

  localparam logic [2:0] ACT_HIT    = 3'd0;
  localparam logic [2:0] ACT_MISS   = 3'd1;
  localparam logic [2:0] ACT_ACCEPT = 3'd2;
  localparam logic [2:0] ACT_REPLY  = 3'd3;
  localparam logic [2:0] ACT_DROP   = 3'd4;

  localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
  localparam logic [15:0] OPCODE_REQUEST = 16'h0001;
  localparam logic [10:0] MIN_ARP_LEN    = 11'd28;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### hw/rtl/arpc_ctrl.sv
// Controller state machine sequencing accept, lookup and commit of one word.
`default_nettype none

module arpc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire arpc_pkg::ctrl_sts_t sts,
  output arpc_pkg::ctrl_cmd_t     cmd
);
  import arpc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.lookup = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_ACT;
      end
      S_ACT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/arpc_dp.sv
// Datapath with the input register, cache entries, MAC memory and result register.
`default_nettype none

module arpc_dp #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::DEF_CACHE_ENTRIES
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire arpc_pkg::ctrl_cmd_t                 cmd,
  output arpc_pkg::ctrl_sts_t                      sts,
  input  wire logic [arpc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic [arpc_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  wire logic [31:0]                         own_ip,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [arpc_pkg::OUT_TDATA_W-1:0]         out_tdata,
  output logic [arpc_pkg::OUT_TUSER_W-1:0]         out_tuser
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic [IN_TDATA_W-1:0]  data_r;
  logic [IN_TUSER_W-1:0]  func_r;

  logic [31:0] ip_in;
  logic [47:0] mac_in;
  logic [31:0] tip_in;
  logic [15:0] hw_in;
  logic [15:0] proto_in;
  logic [15:0] op_in;
  logic [10:0] len_in;

  logic [31:0]              entry_ip_r [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] entry_valid_r;
  logic [47:0]              mac_mem [CACHE_ENTRIES];
  logic [IDX_W-1:0]         next_slot_r;
  logic [IDX_W-1:0]         next_slot_nxt;

  logic [CACHE_ENTRIES-1:0] match;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;

  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [47:0]      mac_rd_r;

  logic             pkt_ok;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [2:0]       action;
  logic [47:0]      mac_res;
  logic [31:0]      ip_res;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  assign ip_in    = data_r[31:0];
  assign mac_in   = data_r[79:32];
  assign tip_in   = data_r[111:80];
  assign hw_in    = data_r[127:112];
  assign proto_in = data_r[143:128];
  assign op_in    = data_r[159:144];
  assign len_in   = data_r[170:160];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r <= in_tdata;
      func_r <= in_tuser;
    end
  end

  always_comb begin
    for (int k = 0; k < CACHE_ENTRIES; k++) begin
      match[k] = entry_valid_r[k] && (entry_ip_r[k] == ip_in);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int k = CACHE_ENTRIES - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_idx = IDX_W'(k);
      end
    end
  end

  assign hit = |match;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r     <= hit;
      hit_idx_r <= hit_idx;
      mac_rd_r  <= mac_mem[hit_idx];
    end
  end

  always_comb begin
    pkt_ok  = (len_in >= MIN_ARP_LEN) && (hw_in == HTYPE_ETHERNET) && (proto_in == PTYPE_IPV4);
    wr_en   = 1'b0;
    action  = ACT_DROP;
    mac_res = '0;
    ip_res  = '0;
    case (func_r)
      FUNC_RESOLVE: begin
        if (hit_r) begin
          action  = ACT_HIT;
          mac_res = mac_rd_r;
        end else begin
          action = ACT_MISS;
          ip_res = ip_in;
        end
      end
      FUNC_PACKET: begin
        if (pkt_ok) begin
          wr_en = 1'b1;
          if ((op_in == OPCODE_REQUEST) && (tip_in == own_ip)) begin
            action  = ACT_REPLY;
            mac_res = mac_in;
            ip_res  = ip_in;
          end else begin
            action = ACT_ACCEPT;
          end
        end
      end
      FUNC_UPDATE: begin
        wr_en  = 1'b1;
        action = ACT_ACCEPT;
      end
      default: action = ACT_DROP;
    endcase
  end

  assign wr_idx = hit_r ? hit_idx_r : next_slot_r;

  always_comb begin
    if (next_slot_r == IDX_W'(CACHE_ENTRIES - 1)) begin
      next_slot_nxt = '0;
    end else begin
      next_slot_nxt = next_slot_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mac_mem[wr_idx] <= mac_in;
      if (!hit_r) begin
        entry_ip_r[next_slot_r] <= ip_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
      next_slot_r   <= '0;
    end else if (cmd.commit && wr_en && !hit_r) begin
      entry_valid_r[next_slot_r] <= 1'b1;
      next_slot_r                <= next_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {ip_res, mac_res};
      out_user_r <= action;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;

endmodule

`default_nettype wire

### hw/rtl/arp_cache_and_responder.sv
// Top level of the ARP cache and responder with its configuration registers.
//
// Channel  Direction  Handshake                 Contents
// in_      input      in_tvalid / in_tready     tdata: request fields, tuser: func
// out_     output     out_tvalid / out_tready   tdata: mac_out, ip_out, tuser: action
// cfg      input      psel / penable / pready   own_ip at 0x0, own_mac at 0x8
//
// A word is accepted in the idle state. The lookup state registers the parallel IP compare
// and MAC memory read, and the act state writes the cache back and loads the result
// register. The input is taken again in the cycle after the commit. A result waiting on
// out_tready holds the commit of the following word. Reset clears all valid bits at once;
// there is no sweep.
`default_nettype none

module arp_cache_and_responder #(
  parameter int unsigned CACHE_ENTRIES = arpc_pkg::DEF_CACHE_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // ip_address[31:0], mac_address[79:32], tgt_ip[111:80], hw_type[127:112],
  // proto_type[143:128], opcode[159:144], pkt_len[170:160], zero fill above.
  input  wire logic [arpc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // func[1:0].
  input  wire logic [arpc_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // mac_out[47:0], ip_out[79:48].
  output logic [arpc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // action[2:0].
  output logic [arpc_pkg::OUT_TUSER_W-1:0]       out_tuser,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [arpc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [arpc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [arpc_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import arpc_pkg::*;

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  logic [31:0] own_ip_r;
  logic [47:0] own_mac_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[3]) begin
        own_mac_r <= pwdata[47:0];
      end else begin
        own_ip_r <= pwdata[31:0];
      end
    end
  end

  assign prdata = paddr[3] ? {16'd0, own_mac_r} : {32'd0, own_ip_r};

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  arpc_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .own_ip     (own_ip_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken again right after an accept.");

  a_no_payload_without_meaning: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ACT_ACCEPT || out_tuser == ACT_DROP) |-> out_tdata == '0)
    else $error("Accept or drop result carries a payload.");

  a_hit_has_no_ip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ACT_HIT |-> out_tdata[79:48] == 32'd0)
    else $error("Hit result carries an IP.");
`endif

endmodule

`default_nettype wire
